@@ hw/rtl/avcc_pkg.sv @@
package avcc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned PSIZE_W  = 3;
    localparam int unsigned SEQ_W    = 2;
    localparam int unsigned USER_W   = 3;

    localparam logic [PSIZE_W-1:0] PSIZE_RESET = 3'd4;
    localparam logic [PSIZE_W-1:0] PSIZE_MIN   = 3'd1;
    localparam logic [PSIZE_W-1:0] PSIZE_MAX   = 3'd4;

    localparam logic [BYTE_W-1:0] SC_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] SC_ONE  = 8'h01;
    localparam logic [SEQ_W-1:0]  SC_TAIL = 2'd3;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_BYTE,
        KIND_START
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } in_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              pend;
        logic              perr;
    } desc_t;

    function automatic logic [PSIZE_W-1:0] eff_prefix(input logic [PSIZE_W-1:0] p);
        logic [PSIZE_W-1:0] r;
        r = p;
        if (p < PSIZE_MIN) r = PSIZE_MIN;
        if (p > PSIZE_MAX) r = PSIZE_MAX;
        return r;
    endfunction

endpackage

@@ hw/rtl/avcc_in_reg.sv @@
module avcc_in_reg
    import avcc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     pop,
    output logic     q_valid,
    output in_item_t q_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready = !valid_reg || pop;

    always_comb begin
        valid_next = valid_reg;
        if (pop) valid_next = 1'b0;
        if (s_valid && s_ready) valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) item_reg <= s_item;
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

@@ hw/rtl/avcc_parser.sv @@
module avcc_parser
    import avcc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [PSIZE_W-1:0] prefix_bytes,
    input  in_item_t           item,
    input  logic               advance,
    output desc_t              desc
);

    logic               in_payload_reg, in_payload_next;
    logic [LEN_W-1:0]   accum_reg, accum_next;
    logic [PSIZE_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;

    logic [LEN_W-1:0]   accum_shift;
    logic [PSIZE_W-1:0] count_inc;
    logic               err;

    always_comb begin
        accum_shift     = {accum_reg[LEN_W-BYTE_W-1:0], item.data};
        count_inc       = count_reg + PSIZE_W'(1);
        in_payload_next = in_payload_reg;
        accum_next      = accum_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        desc.kind       = KIND_NONE;
        desc.data       = item.data;
        desc.valid      = 1'b1;
        desc.pend       = 1'b0;
        desc.perr       = 1'b0;
        err             = 1'b0;

        if (in_payload_reg) begin
            desc.kind       = KIND_BYTE;
            remain_next     = remain_reg - LEN_W'(1);
            in_payload_next = (remain_next != '0);
        end else if (count_inc >= eff_prefix(prefix_bytes)) begin
            desc.kind       = KIND_START;
            remain_next     = accum_shift;
            in_payload_next = (accum_shift != '0);
            accum_next      = '0;
            count_next      = '0;
        end else begin
            accum_next = accum_shift;
            count_next = count_inc;
        end

        if (item.last) begin
            err = (in_payload_next && remain_next != '0) || (count_next != '0);
            if (desc.kind == KIND_NONE) begin
                desc.kind  = KIND_BYTE;
                desc.data  = '0;
                desc.valid = 1'b0;
            end
            desc.pend       = 1'b1;
            desc.perr       = err;
            in_payload_next = 1'b0;
            accum_next      = '0;
            count_next      = '0;
            remain_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg <= 1'b0;
            accum_reg      <= '0;
            count_reg      <= '0;
            remain_reg     <= '0;
        end else if (advance) begin
            in_payload_reg <= in_payload_next;
            accum_reg      <= accum_next;
            count_reg      <= count_next;
            remain_reg     <= remain_next;
        end
    end

endmodule

@@ hw/rtl/avcc_emitter.sv @@
module avcc_emitter
    import avcc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              desc_valid,
    input  desc_t             desc,
    output logic              desc_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic [USER_W-1:0] m_tuser
);

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_bvalid_reg, out_bvalid_next;
    logic              out_end_reg, out_end_next;
    logic              out_err_reg, out_err_next;
    logic              out_rlast_reg, out_rlast_next;
    logic [SEQ_W-1:0]  seq_cnt_reg, seq_cnt_next;
    logic              seq_end_reg, seq_end_next;
    logic              seq_err_reg, seq_err_next;
    logic              adv;

    assign adv        = !out_valid_reg || m_tready;
    assign desc_ready = adv && (seq_cnt_reg == '0);

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_bvalid_next = out_bvalid_reg;
        out_end_next    = out_end_reg;
        out_err_next    = out_err_reg;
        out_rlast_next  = out_rlast_reg;
        seq_cnt_next    = seq_cnt_reg;
        seq_end_next    = seq_end_reg;
        seq_err_next    = seq_err_reg;
        if (adv) begin
            out_valid_next = 1'b0;
            if (seq_cnt_reg != '0) begin
                out_valid_next  = 1'b1;
                out_bvalid_next = 1'b1;
                seq_cnt_next    = seq_cnt_reg - SEQ_W'(1);
                if (seq_cnt_reg == SEQ_W'(1)) begin
                    out_byte_next  = SC_ONE;
                    out_rlast_next = 1'b1;
                    out_end_next   = seq_end_reg;
                    out_err_next   = seq_err_reg;
                end else begin
                    out_byte_next  = SC_ZERO;
                    out_rlast_next = 1'b0;
                    out_end_next   = 1'b0;
                    out_err_next   = 1'b0;
                end
            end else if (desc_valid) begin
                unique case (desc.kind)
                    KIND_BYTE: begin
                        out_valid_next  = 1'b1;
                        out_byte_next   = desc.data;
                        out_bvalid_next = desc.valid;
                        out_end_next    = desc.pend;
                        out_err_next    = desc.perr;
                        out_rlast_next  = 1'b1;
                    end
                    KIND_START: begin
                        out_valid_next  = 1'b1;
                        out_byte_next   = SC_ZERO;
                        out_bvalid_next = 1'b1;
                        out_end_next    = 1'b0;
                        out_err_next    = 1'b0;
                        out_rlast_next  = 1'b0;
                        seq_cnt_next    = SC_TAIL;
                        seq_end_next    = desc.pend;
                        seq_err_next    = desc.perr;
                    end
                    default: begin
                        out_valid_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            seq_cnt_reg   <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            seq_cnt_reg   <= seq_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg   <= out_byte_next;
        out_bvalid_reg <= out_bvalid_next;
        out_end_reg    <= out_end_next;
        out_err_reg    <= out_err_next;
        out_rlast_reg  <= out_rlast_next;
        seq_end_reg    <= seq_end_next;
        seq_err_reg    <= seq_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_end_reg;
    assign m_tuser  = {out_rlast_reg, out_err_reg, out_bvalid_reg};

endmodule

@@ hw/rtl/avcc_to_annexb_converter_unit.sv @@
// A request passes through the input register and then the output register before its first result.
// One payload byte per cycle while the output is not stalled; a byte that completes a length
// prefix yields the four start-code results from the output sequencer, holding input meanwhile.
// Reset (aresetn low, synchronous): registers empty, parser back to prefix reading,
// prefix size returns to 4 bytes.
module avcc_to_annexb_converter_unit
    import avcc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [PSIZE_W-1:0] cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [BYTE_W-1:0]  m_tdata,   // [7:0] out_byte
    output logic               m_tlast,
    output logic [USER_W-1:0]  m_tuser    // [0] byte_valid, [1] packet_error, [2] run_last
);

    logic [PSIZE_W-1:0] prefix_reg;
    in_item_t           s_item;
    in_item_t           q_item;
    logic               q_valid;
    logic               desc_ready;
    logic               pop;
    desc_t              desc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= PSIZE_RESET;
        end else if (cfg_we) begin
            prefix_reg <= cfg_wdata;
        end
    end

    assign s_item.data = s_tdata;
    assign s_item.last = s_tlast;
    assign pop         = q_valid && desc_ready;

    avcc_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .pop     (pop),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    avcc_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .prefix_bytes (prefix_reg),
        .item         (q_item),
        .advance      (pop),
        .desc         (desc)
    );

    avcc_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (q_valid),
        .desc       (desc),
        .desc_ready (desc_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

@@ hw/rtl/avcc_checker.sv @@
module avcc_checker
    import avcc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [BYTE_W-1:0]  m_tdata,
    input logic               m_tlast,
    input logic [USER_W-1:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

    a_empty_is_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && m_tuser[2] && m_tdata == '0)
        else $error("byteless result is not a packet error end");

    a_err_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("error flag without packet end");

    a_end_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[2])
        else $error("packet end not on last result of a request");

    a_reset_empty: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_tvalid)
        else $error("result presented right after reset");

endmodule

bind avcc_to_annexb_converter_unit avcc_checker u_avcc_checker (.*);
